>>> hw/rtl/rdpd_pkg.sv
// Shared types and constants for the remote debug packet deframer.
package rdpd_pkg;

   localparam int unsigned LENGTH_BITS = 16;
   localparam logic [LENGTH_BITS-1:0] LENGTH_ONE = {{(LENGTH_BITS-1){1'b0}}, 1'b1};
   localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = {LENGTH_BITS{1'b1}};

   localparam logic [7:0] CHAR_SOF  = 8'h24;
   localparam logic [7:0] CHAR_EOF  = 8'h23;
   localparam logic [7:0] CHAR_ACK  = 8'h2b;
   localparam logic [7:0] CHAR_NAK  = 8'h2d;
   localparam logic [7:0] CHAR_INTR = 8'h03;
   localparam logic [7:0] NOT_HEX   = 8'hff;

   localparam logic [2:0] EV_NONE      = 3'd0;
   localparam logic [2:0] EV_DATA      = 3'd1;
   localparam logic [2:0] EV_ACK       = 3'd2;
   localparam logic [2:0] EV_INTR      = 3'd3;
   localparam logic [2:0] EV_GOOD      = 3'd4;
   localparam logic [2:0] EV_BAD       = 3'd5;
   localparam logic [2:0] EV_MALFORMED = 3'd6;
   localparam logic [2:0] EV_DISCARD   = 3'd7;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       ack_expected;
   } req_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [7:0]  data_byte;
      logic [7:0]  computed_sum;
      logic [7:0]  received_sum;
      logic [15:0] payload_length;
      logic [7:0]  reply_byte;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      req_type item;
   } stage_type;

endpackage

>>> hw/rtl/rdpd_in_reg.sv
// Input register stage: captures one received item and holds it until taken.
module rdpd_in_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rdpd_pkg::req_type req_item,
   input  logic              take,
   output rdpd_pkg::stage_type stage
);
   import rdpd_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   req_type item_ff;

   assign req_stall = valid_ff && !take;
   assign valid_in  = req_stall ? valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_valid && !req_stall) begin
         item_ff <= req_item;
      end
   end

   assign stage = '{valid: valid_ff, item: item_ff};

endmodule

>>> hw/rtl/rdpd_frame.sv
// Framing state machine, checksum check and result register.
module rdpd_frame (
   input  logic                clock,
   input  logic                reset,
   input  rdpd_pkg::stage_type stage,
   output logic                take,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rdpd_pkg::rsp_type   rsp_item
);
   import rdpd_pkg::*;

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_PAYLOAD = 2'd1,
      PH_HIGH    = 2'd2,
      PH_LOW     = 2'd3
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [7:0]             sum_ff, sum_in;
   logic [7:0]             high_ff, high_in;
   logic [LENGTH_BITS-1:0] length_ff, length_in;
   logic [7:0]             command_ff, command_in;
   logic                   rsp_valid_ff;
   rsp_type                rsp_ff, rsp_in;
   logic [7:0]             rx;
   logic [7:0]             got;

   function automatic logic [7:0] hex_worth(input logic [7:0] c);
      logic [7:0] v;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = c - 8'h30;
      end else if (c >= 8'h61 && c <= 8'h66) begin
         v = c - 8'h57;
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = c - 8'h37;
      end else begin
         v = NOT_HEX;
      end
      return v;
   endfunction

   assign take = stage.valid && (!rsp_valid_ff || !rsp_stall);
   assign rx   = stage.item.rx_byte;
   assign got  = hex_worth(rx) + {high_ff[3:0], 4'b0000};

   always_comb begin
      phase_in   = phase_ff;
      sum_in     = sum_ff;
      high_in    = high_ff;
      length_in  = length_ff;
      command_in = command_ff;
      rsp_in     = '0;
      priority if (phase_ff == PH_IDLE) begin
         priority if (rx == CHAR_SOF) begin
            phase_in   = PH_PAYLOAD;
            sum_in     = '0;
            high_in    = '0;
            length_in  = '0;
            command_in = '0;
         end else if (rx == CHAR_ACK && stage.item.ack_expected) begin
            rsp_in.event_res = EV_ACK;
         end else if (rx == CHAR_INTR) begin
            rsp_in.event_res = EV_INTR;
         end else begin
            rsp_in.event_res = EV_DISCARD;
         end
      end else if (rx == CHAR_SOF) begin
         rsp_in.event_res      = EV_MALFORMED;
         rsp_in.payload_length = 16'(length_ff);
         phase_in   = PH_PAYLOAD;
         sum_in     = '0;
         high_in    = '0;
         length_in  = '0;
         command_in = '0;
      end else begin
         unique case (phase_ff)
            PH_PAYLOAD: begin
               if (rx == CHAR_EOF) begin
                  phase_in = PH_HIGH;
               end else begin
                  if (length_ff == '0) begin
                     command_in = rx;
                  end
                  sum_in = sum_ff + rx;
                  if (length_ff != LENGTH_MAX) begin
                     length_in = length_ff + LENGTH_ONE;
                  end
                  rsp_in.event_res = EV_DATA;
                  rsp_in.data_byte = rx;
               end
            end
            PH_HIGH: begin
               high_in  = hex_worth(rx);
               phase_in = PH_LOW;
            end
            PH_LOW: begin
               if (got == sum_ff) begin
                  rsp_in.event_res  = EV_GOOD;
                  rsp_in.reply_byte = CHAR_ACK;
               end else begin
                  rsp_in.event_res  = EV_BAD;
                  rsp_in.reply_byte = CHAR_NAK;
               end
               rsp_in.data_byte      = command_ff;
               rsp_in.computed_sum   = sum_ff;
               rsp_in.received_sum   = got;
               rsp_in.payload_length = 16'(length_ff);
               phase_in = PH_IDLE;
            end
            PH_IDLE: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         sum_ff       <= '0;
         high_ff      <= '0;
         length_ff    <= '0;
         command_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         phase_ff     <= phase_in;
         sum_ff       <= sum_in;
         high_ff      <= high_in;
         length_ff    <= length_in;
         command_ff   <= command_in;
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

>>> hw/rtl/remote_debug_packet_deframer_top.sv
// Top level of the remote debug packet deframer.
// Takes one received byte per clock and returns exactly one result item for each
// byte. An item passes an input register and then the framing logic into a result
// register, which presents the result; while the result side does not stall the
// sustained rate is one item per clock, and a stall on the result side holds the
// result register and then the input register. Packets are $payload#hh: payload
// bytes come out one by one, and the low checksum digit yields the good/bad
// report with the command byte, both sums, the saturated length and the reply byte.
module remote_debug_packet_deframer_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rdpd_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rdpd_pkg::rsp_type rsp_item
);
   import rdpd_pkg::*;

   stage_type stage;
   logic      take;

   rdpd_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .take      (take),
      .stage     (stage)
   );

   rdpd_frame u_frame (
      .clock     (clock),
      .reset     (reset),
      .stage     (stage),
      .take      (take),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule
